// ===== rtl/skyline_rectangle_placer_assert.svh =====
// Assertion macros shared by the checker.
`ifndef SKYLINE_RECTANGLE_PLACER_ASSERT_SVH
`define SKYLINE_RECTANGLE_PLACER_ASSERT_SVH
// Implication checked every clock, not during reset.
`define SRP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Implication checked on the clock after the antecedent.
`define SRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== rtl/srp_pkg.sv =====
`timescale 1ns / 1ps
package srp_pkg;
  localparam int MaxColumns = 1024;
  localparam int AddrW = $clog2(MaxColumns);
  localparam int ColCntW = AddrW + 1;
  localparam int HeightW = 16;
  localparam int DimW = 16;

  localparam logic [1:0] RegBinWidth = 2'd0;
  localparam logic [1:0] RegBinHeight = 2'd1;
  localparam logic [1:0] RegAllowRotate = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN_RD,
    ST_SCAN,
    ST_SCAN_END,
    ST_PICK,
    ST_WRITE,
    ST_OUT
  } state_t;

  // Result of one orientation scan.
  typedef struct packed {
    logic found;
    logic [AddrW-1:0] x;
    logic [HeightW-1:0] y;
  } spot_t;
endpackage

// ===== rtl/srp_ram.sv =====
`timescale 1ns / 1ps
module srp_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/srp_window.sv =====
`timescale 1ns / 1ps
// Sliding-window maximum over the skyline stream: a monotone deque held in
// one memory whose entries pair each column index with its height.
module srp_window import srp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               col_valid,
  input  logic [AddrW-1:0]   col_idx,
  input  logic [HeightW-1:0] col_h,
  input  logic [DimW-1:0]    win_w,
  input  logic [DimW-1:0]    form_h,
  input  logic [HeightW-1:0] bin_h,
  output logic               busy,
  output spot_t              spot
);
  // The deque is kept only as a stack of (index, height) with head and
  // tail pointers. Pops from the tail need the tail entry, which is held in
  // registers and refreshed from memory after a pop that leaves entries, stalling the unit.
  logic [ColCntW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AddrW-1:0]   head_idx_r, head_idx_nxt;
  logic [HeightW-1:0] head_h_r, head_h_nxt;
  logic [AddrW-1:0]   top_idx_r, top_idx_nxt;
  logic [HeightW-1:0] top_h_r, top_h_nxt;
  logic               pend_r, pend_nxt;
  logic [AddrW-1:0]   pidx_r, pidx_nxt;
  logic [HeightW-1:0] ph_r, ph_nxt;
  logic [1:0]         wait_r, wait_nxt;
  spot_t              spot_r, spot_nxt;
  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [AddrW+HeightW-1:0] wdata, rdata;

  srp_ram #(.Width(AddrW + HeightW), .Depth(MaxColumns)) u_deque (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy = pend_r || (wait_r != 2'd0);
  assign spot = spot_r;

  always_comb begin
    logic [HeightW-1:0] hh_use;
    logic [DimW:0]      expire;
    logic [ColCntW:0]   endc;
    logic [HeightW:0]   top;
    head_nxt = head_r;
    tail_nxt = tail_r;
    head_idx_nxt = head_idx_r;
    head_h_nxt = head_h_r;
    top_idx_nxt = top_idx_r;
    top_h_nxt = top_h_r;
    pend_nxt = pend_r;
    pidx_nxt = pidx_r;
    ph_nxt = ph_r;
    wait_nxt = wait_r;
    spot_nxt = spot_r;
    we = 1'b0;
    waddr = pidx_r;
    wdata = {pidx_r, ph_r};
    raddr = '0;
    hh_use = head_h_r;
    expire = '0;
    endc = '0;
    top = '0;
    if (start) begin
      head_nxt = '0;
      tail_nxt = '0;
      pend_nxt = 1'b0;
      wait_nxt = 2'd0;
      spot_nxt = '0;
    end else if (wait_r == 2'd2) begin
      // Read issued last cycle for the tail entry after a pop.
      {top_idx_nxt, top_h_nxt} = rdata;
      wait_nxt = 2'd0;
    end else if (wait_r == 2'd3) begin
      {head_idx_nxt, head_h_nxt} = rdata;
      wait_nxt = 2'd0;
    end else if (pend_r) begin
      if (tail_r > head_r && top_h_r <= ph_r) begin
        // Pop the tail and fetch the new tail entry.
        tail_nxt = tail_r - 1'b1;
        if (tail_r - 1'b1 > head_r) begin
          raddr = AddrW'(tail_r - 2'd2);
          wait_nxt = 2'd2;
        end
      end else begin
        // Push the pending column.
        we = 1'b1;
        waddr = tail_r[AddrW-1:0];
        tail_nxt = tail_r + 1'b1;
        top_idx_nxt = pidx_r;
        top_h_nxt = ph_r;
        pend_nxt = 1'b0;
        if (tail_r == head_r) begin
          head_idx_nxt = pidx_r;
          head_h_nxt = ph_r;
          hh_use = ph_r;
        end
        // Evaluate a window ending at this column.
        endc = {1'b0, pidx_r} + 1'b1;
        if ({{(DimW-ColCntW){1'b0}}, endc} >= {1'b0, win_w}) begin
          top = {1'b0, hh_use} + {1'b0, form_h};
          if (top <= {1'b0, bin_h} && (!spot_r.found || hh_use < spot_r.y)) begin
            spot_nxt.found = 1'b1;
            spot_nxt.y = hh_use;
            spot_nxt.x = AddrW'(endc - (ColCntW+1)'(win_w));
          end
        end
      end
    end else if (col_valid) begin
      // Expire the head if it leaves the window at this column.
      expire = {1'b0, head_idx_r} + {1'b0, win_w};
      if (tail_r > head_r && expire[DimW-1:0] == DimW'(col_idx) && expire[DimW] == 1'b0) begin
        head_nxt = head_r + 1'b1;
        if (head_r + 1'b1 < tail_r) begin
          raddr = AddrW'(head_r + 1'b1);
          wait_nxt = 2'd3;
        end
      end
      pend_nxt = 1'b1;
      pidx_nxt = col_idx;
      ph_nxt = col_h;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      pend_r <= 1'b0;
      wait_r <= 2'd0;
      spot_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      pend_r <= pend_nxt;
      wait_r <= wait_nxt;
      spot_r <= spot_nxt;
    end
    head_idx_r <= head_idx_nxt;
    head_h_r <= head_h_nxt;
    top_idx_r <= top_idx_nxt;
    top_h_r <= top_h_nxt;
    pidx_r <= pidx_nxt;
    ph_r <= ph_nxt;
  end
endmodule

// ===== rtl/skyline_rectangle_placer.sv =====
`timescale 1ns / 1ps
// Skyline bottom-left rectangle placer.
// Input channel (in_valid/in_ready): one request per transfer. in_mode 1
// clears the skyline, in_mode 0 places a rectangle in_rect_width by
// in_rect_height. Output channel (out_valid/out_ready): exactly one result
// per request, with out_placed, out_pos_x, out_pos_y and out_rotated; all
// zero for a clear request or when nothing fits.
// The configuration port writes bin_width, bin_height and the rotation
// enable by index; write only while idle.
// A clear writes zero to all MaxColumns columns, one column per cycle, and then
// shows its result. A placement scans the W used columns once per orientation
// that fits (twice with rotation on). Each column is read from the skyline memory, taken
// by the window unit and pushed; a deque pop or head expiry can stall the scan
// while the window unit refreshes its cached entry from memory. The covered
// columns are then rewritten one per cycle. The window unit takes one column
// at a time, and the block takes one request at a time.
// Reset zeroes the skyline by a clearing pass over all MaxColumns columns, during
// which in_ready stays low. When the receiver stalls, the result waits in the
// output register and no new request is taken until it is transferred.
module skyline_rectangle_placer import srp_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic [DimW-1:0]     in_rect_width,
  input  logic [DimW-1:0]     in_rect_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_placed,
  output logic [AddrW-1:0]    out_pos_x,
  output logic [HeightW-1:0]  out_pos_y,
  output logic                out_rotated,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [HeightW-1:0]  cfg_data
);
  state_t state_r, state_nxt;
  logic [10:0]          bin_width_r;
  logic [HeightW-1:0]   bin_height_r;
  logic                 rot_en_r;
  logic [DimW-1:0]      rw_r, rh_r;
  logic                 rot_pass_r, rot_pass_nxt;
  logic [ColCntW-1:0]   cnt_r, cnt_nxt;
  logic                 rd_v_r, rd_v_nxt;
  logic [AddrW-1:0]     rd_idx_r;
  spot_t                spot0_r;
  logic [AddrW-1:0]     px_r;
  logic [HeightW-1:0]   py_r;
  logic [DimW-1:0]      pw_r;
  logic [HeightW-1:0]   top_r;
  logic                 rot_r;
  logic                 placed_r;
  logic                 out_valid_r;
  logic                 mode_is_req_r;
  logic [ColCntW-1:0]   cols;
  logic [DimW-1:0]      form_w, form_h;
  logic                 form_ok;
  logic                 sky_we;
  logic [AddrW-1:0]     sky_waddr, sky_raddr;
  logic [HeightW-1:0]   sky_wdata, sky_rdata;
  logic                 win_start, win_busy;
  spot_t                win_spot;

  assign cols = (bin_width_r > 11'(MaxColumns)) ? ColCntW'(MaxColumns)
                                                 : ColCntW'(bin_width_r);
  assign form_w = rot_pass_r ? rh_r : rw_r;
  assign form_h = rot_pass_r ? rw_r : rh_r;
  assign form_ok = form_w != '0 && form_h != '0 && form_w <= DimW'(cols) &&
                   form_h <= bin_height_r;

  srp_ram #(.Width(HeightW), .Depth(MaxColumns)) u_sky (
    .clk(clk), .we(sky_we), .waddr(sky_waddr), .wdata(sky_wdata),
    .raddr(sky_raddr), .rdata(sky_rdata)
  );

  srp_window u_win (
    .clk(clk), .rst_n(rst_n), .start(win_start), .col_valid(rd_v_r),
    .col_idx(rd_idx_r), .col_h(sky_rdata), .win_w(form_w), .form_h(form_h),
    .bin_h(bin_height_r), .busy(win_busy), .spot(win_spot)
  );

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_placed = placed_r;
  assign out_pos_x = placed_r ? px_r : '0;
  assign out_pos_y = placed_r ? py_r : '0;
  assign out_rotated = placed_r & rot_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = in_mode ? ST_CLEAR : ST_SCAN_RD;
        end
      end
      ST_CLEAR: begin
        if (cnt_r == ColCntW'(MaxColumns - 1)) state_nxt = ST_OUT;
      end
      ST_SCAN_RD: begin
        state_nxt = form_ok ? ST_SCAN : ST_SCAN_END;
      end
      ST_SCAN: begin
        if (!win_busy && !rd_v_r && cnt_r == cols) state_nxt = ST_SCAN_END;
      end
      ST_SCAN_END: begin
        if (!rot_pass_r && rot_en_r) state_nxt = ST_SCAN_RD;
        else state_nxt = ST_PICK;
      end
      ST_PICK: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!placed_r || {1'b0, cnt_r} >= {1'b0, px_r} + {2'b0, pw_r} ||
            cnt_r == ColCntW'(MaxColumns)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath controls.
  always_comb begin
    cnt_nxt = cnt_r;
    rd_v_nxt = 1'b0;
    rot_pass_nxt = rot_pass_r;
    sky_we = 1'b0;
    sky_waddr = cnt_r[AddrW-1:0];
    sky_wdata = '0;
    sky_raddr = cnt_r[AddrW-1:0];
    win_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        rot_pass_nxt = 1'b0;
      end
      ST_CLEAR: begin
        sky_we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_SCAN_RD: begin
        win_start = 1'b1;
        cnt_nxt = '0;
      end
      ST_SCAN: begin
        if (!win_busy && !rd_v_r && cnt_r < cols) begin
          rd_v_nxt = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SCAN_END: begin
        rot_pass_nxt = 1'b1;
      end
      ST_PICK: begin
        cnt_nxt = {1'b0, px_r};
      end
      ST_WRITE: begin
        if (placed_r && {1'b0, cnt_r} < {1'b0, px_r} + {2'b0, pw_r} &&
            cnt_r != ColCntW'(MaxColumns)) begin
          sky_we = 1'b1;
          sky_wdata = top_r;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r <= '0;
      rd_v_r <= 1'b0;
      rot_pass_r <= 1'b0;
      out_valid_r <= 1'b0;
      placed_r <= 1'b0;
      bin_width_r <= 11'd1024;
      bin_height_r <= 16'hFFFF;
      rot_en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rd_v_r <= rd_v_nxt;
      rot_pass_r <= rot_pass_nxt;
      if (cfg_we) begin
        case (cfg_index)
          RegBinWidth: bin_width_r <= cfg_data[10:0];
          RegBinHeight: bin_height_r <= cfg_data;
          RegAllowRotate: rot_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && in_valid && in_ready) placed_r <= 1'b0;
      if (state_r == ST_SCAN_END) begin
        if (!rot_pass_r) begin
          placed_r <= form_ok && win_spot.found;
        end else if (form_ok && win_spot.found &&
                     (!spot0_r.found || win_spot.y < spot0_r.y ||
                      (win_spot.y == spot0_r.y && win_spot.x < spot0_r.x))) begin
          placed_r <= 1'b1;
        end
      end
      if (state_r == ST_OUT) out_valid_r <= mode_is_req_r;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  // A request is pending from its transfer until ST_OUT; the reset clearing
  // pass also ends in ST_OUT but produces no result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_is_req_r <= 1'b0;
    end else if (state_r == ST_IDLE && in_valid && in_ready) begin
      mode_is_req_r <= 1'b1;
    end else if (state_r == ST_OUT) begin
      mode_is_req_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && in_ready) begin
      rw_r <= in_rect_width;
      rh_r <= in_rect_height;
    end
    rd_idx_r <= cnt_r[AddrW-1:0];
    if (state_r == ST_SCAN_END) begin
      if (!rot_pass_r) begin
        spot0_r <= (form_ok && win_spot.found) ? win_spot : '0;
        px_r <= win_spot.x;
        py_r <= win_spot.y;
        pw_r <= rw_r;
        top_r <= win_spot.y + rh_r;
        rot_r <= 1'b0;
      end else if (form_ok && win_spot.found &&
                   (!spot0_r.found || win_spot.y < spot0_r.y ||
                    (win_spot.y == spot0_r.y && win_spot.x < spot0_r.x))) begin
        px_r <= win_spot.x;
        py_r <= win_spot.y;
        pw_r <= rh_r;
        top_r <= win_spot.y + rw_r;
        rot_r <= 1'b1;
      end
    end
  end
endmodule

// ===== rtl/srp_checker.sv =====
`timescale 1ns / 1ps
`include "skyline_rectangle_placer_assert.svh"
module srp_checker import srp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_placed,
  input logic [AddrW-1:0] out_pos_x,
  input logic [HeightW-1:0] out_pos_y,
  input logic out_rotated
);
  // One request at a time: no new transfer while a result waits.
  `SRP_ASSERT_IMPL(a_no_accept_with_result, out_valid, !in_ready)
  // Unplaced results are all zero.
  `SRP_ASSERT_IMPL(a_zero_when_unplaced, out_valid && !out_placed,
                   out_pos_x == '0 && out_pos_y == '0 && !out_rotated)
  // A result is not shown in the cycle right after a request transfer.
  `SRP_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !out_valid)
  // A stalled result stays valid and holds its position.
  `SRP_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
                   out_valid && $stable(out_pos_y) && $stable(out_pos_x))
endmodule

bind skyline_rectangle_placer srp_checker u_srp_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_placed(out_placed),
  .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_rotated(out_rotated)
);

// ===== tb/tb_skyline_rectangle_placer.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the skyline rectangle placer. Requests go in over a
// valid/ready channel, each accepted transfer is run through a local skyline
// predictor, and every result transfer is compared against the oldest
// prediction still waiting.
module tb_skyline_rectangle_placer;
  import srp_pkg::*;

  // The index port is two bits wide, so the fourth index exists but maps to
  // no register. Writes to it must leave everything alone.
  localparam logic [1:0] RegUnmapped = 2'd3;
  localparam logic ModePlace = 1'b0;
  localparam logic ModeClear = 1'b1;
  localparam int MaxGap = 13;

  typedef struct packed {
    logic placed;
    logic [AddrW-1:0] x;
    logic [HeightW-1:0] y;
    logic rotated;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_mode;
  logic [DimW-1:0] in_rect_width;
  logic [DimW-1:0] in_rect_height;
  logic out_valid;
  logic out_ready;
  logic out_placed;
  logic [AddrW-1:0] out_pos_x;
  logic [HeightW-1:0] out_pos_y;
  logic out_rotated;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [HeightW-1:0] cfg_data;

  skyline_rectangle_placer dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Local copy of the skyline and of the three registers.
  logic [HeightW-1:0] sky_heights [MaxColumns];
  logic [10:0] cur_bin_width;
  logic [HeightW-1:0] cur_bin_height;
  logic cur_rotate;

  placement_t pending_places[$];
  int mismatches = 0;
  // When set, neither side inserts idle cycles.
  bit no_gaps = 1'b0;

  function automatic int unsigned columns_in_use();
    return (cur_bin_width > MaxColumns) ? MaxColumns : cur_bin_width;
  endfunction

  // Lowest, then leftmost, spot for a form ww wide and hh tall. The bottom of
  // a spot is the tallest column under it.
  function automatic bit lowest_spot(input int unsigned ww, input int unsigned hh,
                                     output int unsigned bx, output int unsigned by);
    int unsigned cols;
    int unsigned top;
    bit hit;
    cols = columns_in_use();
    hit = 1'b0;
    bx = 0;
    by = 0;
    if (ww == 0 || hh == 0 || ww > cols || hh > cur_bin_height) return 1'b0;
    for (int unsigned sx = 0; sx + ww <= cols; sx++) begin
      top = 0;
      for (int unsigned c = sx; c < sx + ww; c++)
        if (sky_heights[c] > top) top = sky_heights[c];
      // Strict compare keeps the leftmost spot on a tie in height.
      if (top + hh <= cur_bin_height && (!hit || top < by)) begin
        hit = 1'b1;
        bx = sx;
        by = top;
      end
    end
    return hit;
  endfunction

  // Works out the result of one request and updates the local skyline.
  function automatic placement_t place_rectangle(input logic mode,
                                                 input logic [DimW-1:0] rw,
                                                 input logic [DimW-1:0] rh);
    placement_t res;
    int unsigned x0, y0, x1, y1, px, py, pw, ph;
    bit fit0, fit1;
    res = '0;
    if (mode == ModeClear) begin
      foreach (sky_heights[i]) sky_heights[i] = '0;
      return res;
    end
    fit0 = lowest_spot(32'(rw), 32'(rh), x0, y0);
    fit1 = cur_rotate ? lowest_spot(32'(rh), 32'(rw), x1, y1) : 1'b0;
    if (!fit0 && !fit1) return res;
    // The turned form wins when the plain one does not fit, or when strictly lower, or level and further left.
    if (fit1 && (!fit0 || y1 < y0 || (y1 == y0 && x1 < x0))) begin
      px = x1; py = y1; pw = 32'(rh); ph = 32'(rw); res.rotated = 1'b1;
    end else begin
      px = x0; py = y0; pw = 32'(rw); ph = 32'(rh);
    end
    for (int unsigned c = px; c < px + pw && c < MaxColumns; c++)
      sky_heights[c] = HeightW'(py + ph);
    res.placed = 1'b1;
    res.x = px[AddrW-1:0];
    res.y = py[HeightW-1:0];
    return res;
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, MaxGap);
  endfunction

  // Sends one request. Called at a rising edge and returns at the edge of the
  // transfer; in_valid stays high so a back-to-back request keeps it up.
  task automatic send_request(input logic mode, input logic [DimW-1:0] rw,
                              input logic [DimW-1:0] rh);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_rect_width <= rw;
    in_rect_height <= rh;
    do @(posedge clk); while (!in_ready);
    pending_places.insert(pending_places.size(), place_rectangle(mode, rw, rh));
  endtask

  // Stops sending and waits until every predicted result has been seen, then
  // lets a few more cycles pass so the block is surely back in its idle state.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_places.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register writes happen only after wait_idle has returned.
  task automatic write_reg(input logic [1:0] idx, input logic [HeightW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegBinWidth: cur_bin_width = value[10:0];
      RegBinHeight: cur_bin_height = value;
      RegAllowRotate: cur_rotate = value[0];
      default: ;
    endcase
  endtask

  task automatic set_bin(input int w, input int h, input logic rot);
    write_reg(RegBinWidth, w[HeightW-1:0]);
    write_reg(RegBinHeight, h[HeightW-1:0]);
    write_reg(RegAllowRotate, {{(HeightW-1){1'b0}}, rot});
  endtask

  // Result side: a random stall before each transfer, then the check itself.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_places.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing expected: placed %0b x %0d y %0d rot %0b",
                   $realtime, out_placed, out_pos_x, out_pos_y, out_rotated);
      end else begin
        want = pending_places[0];
        pending_places.delete(0);
        if (out_placed !== want.placed || out_pos_x !== want.x ||
            out_pos_y !== want.y || out_rotated !== want.rotated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected placed %0b x %0d y %0d rot %0b, got placed %0b x %0d y %0d rot %0b",
                     $realtime, want.placed, want.x, want.y, want.rotated,
                     out_placed, out_pos_x, out_pos_y, out_rotated);
        end
      end
    end
  end

  // Corners with the reset registers: full width of 1024 columns, full height.
  task automatic test_reset_defaults();
    send_request(ModePlace, 16'd1024, 16'd1);     // spans the whole bin
    send_request(ModePlace, 16'd1, 16'd65535);    // would end above the bin
    send_request(ModePlace, 16'hFFFF, 16'd1);     // wider than the bin
    send_request(ModePlace, 16'd0, 16'd5);        // zero width never fits
    send_request(ModePlace, 16'd7, 16'd0);        // zero height never fits
    send_request(ModePlace, 16'd3, 16'd65534);    // ends exactly at the top
    send_request(ModeClear, 16'hFFFF, 16'hFFFF);
    send_request(ModePlace, 16'd1, 16'd1);
    wait_idle();
  endtask

  // Register extremes, the ignored index, and the rotation tie rules.
  task automatic test_register_corners();
    set_bin(0, 100, 1'b0);                        // no column at all
    send_request(ModePlace, 16'd1, 16'd1);
    wait_idle();
    write_reg(RegBinWidth, 16'd2047);             // capped at the column count
    write_reg(RegUnmapped, 16'hFFFF);
    send_request(ModePlace, 16'd1, 16'd1);
    wait_idle();
    set_bin(16'hF801, 0, 1'b0);                   // upper data bits dropped; no height
    send_request(ModePlace, 16'd1, 16'd1);
    wait_idle();
    set_bin(1, 1, 1'b0);
    send_request(ModeClear, 16'd0, 16'd0);
    send_request(ModePlace, 16'd1, 16'd1);
    send_request(ModePlace, 16'd1, 16'd1);        // column now full
    wait_idle();
    set_bin(4, 100, 1'b1);
    send_request(ModeClear, 16'd0, 16'd0);
    send_request(ModePlace, 16'd10, 16'd2);       // fits only turned
    send_request(ModePlace, 16'd2, 16'd2);        // square ties, stays unturned
    send_request(ModePlace, 16'd3, 16'd0);        // both forms have a zero side
    send_request(ModePlace, 16'd1, 16'd3);        // unturned form is lower
    wait_idle();
  endtask

  // One random phase: mostly rectangles that fit the bin, some clears, and
  // some noise across the full range of every field.
  task automatic run_phase(input int w, input int h, input logic rot, input int n,
                           input bit hold_midway);
    int pick;
    logic [DimW-1:0] rw, rh;
    set_bin(w, h, rot);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (hold_midway && k == n / 2) wait_idle();
      if (pick < 5) begin
        send_request(ModeClear, DimW'($urandom), DimW'($urandom));
      end else if (pick < 12) begin
        send_request(ModePlace, DimW'($urandom), DimW'($urandom));
      end else begin
        rw = DimW'($urandom_range(1, (w > 0 && w < 1024) ? w : 8));
        rh = DimW'($urandom_range(1, (h / 4 > 0) ? h / 4 : 1));
        send_request(ModePlace, rw, rh);
      end
    end
    wait_idle();
  endtask

  task automatic test_random_phases();
    run_phase(16, 60, 1'b1, 45, 1'b1);
    run_phase(1, 200, 1'b0, 20, 1'b0);
    no_gaps = 1'b1;
    run_phase(32, 120, 1'b1, 45, 1'b0);
    no_gaps = 1'b0;
    run_phase(64, 65535, 1'b0, 40, 1'b0);
    run_phase($urandom_range(2, 48), $urandom_range(10, 300), 1'b1, 50, 1'b1);
    run_phase(8, 30, 1'b0, 40, 1'b0);
    run_phase(1024, 65535, 1'b1, 10, 1'b0);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_mode <= ModePlace;
    in_rect_width <= '0;
    in_rect_height <= '0;
    cfg_we <= 1'b0;
    cfg_index <= RegBinWidth;
    cfg_data <= '0;
    foreach (sky_heights[i]) sky_heights[i] = '0;
    cur_bin_width = 11'd1024;
    cur_bin_height = 16'hFFFF;
    cur_rotate = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_corners();
    test_random_phases();

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_places.size() == 0)
      $display("** skyline_rectangle_placer: PASSED **");
    else
      $display("** skyline_rectangle_placer: FAILED **");
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(64'd400_000_000);
    $display("** skyline_rectangle_placer: FAILED **");
    $finish;
  end
endmodule
